// ===== design/tccc_pkg.sv =====
`default_nettype none

package tccc_pkg;

    localparam int unsigned COL_W = 9;
    localparam int unsigned ROW_W = 8;
    localparam int unsigned WRAP_W = 16;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned COLS_CFG_W = 10;
    localparam int unsigned ROWS_CFG_W = 9;

    localparam logic [COLS_CFG_W-1:0] MAX_COLUMNS = 10'd512;
    localparam logic [ROWS_CFG_W-1:0] MAX_ROWS = 9'd256;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    localparam logic [WRAP_W-1:0] WRAP_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 8'd3;

    localparam logic [COL_W-1:0] RESET_COL_LAST = 9'd79;
    localparam logic [ROW_W-1:0] RESET_ROW_LAST = 8'd24;
    localparam logic [COLOR_W-1:0] RESET_TEXT_COLOR = 32'h00AA_AAAA;
    localparam logic [COLOR_W-1:0] RESET_BACK_COLOR = 32'h0000_0000;

    typedef enum logic [3:0] {
        OP_NEWLINE   = 4'b0001,
        OP_RETURN    = 4'b0010,
        OP_BACKSPACE = 4'b0100,
        OP_GLYPH     = 4'b1000
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CHAR_W-1:0] code;
    } queue_entry_t;

    typedef struct packed {
        logic [COL_W-1:0]   col_last;
        logic [ROW_W-1:0]   row_last;
        logic [COLOR_W-1:0] text_color;
        logic [COLOR_W-1:0] back_color;
        logic               home;
    } cursor_cfg_t;

endpackage

`default_nettype wire

// ===== design/tccc_front.sv =====
`default_nettype none

module tccc_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             char_code,
    output logic                        head_valid,
    output tccc_pkg::queue_entry_t      head,
    input  wire logic                   pop
);
    import tccc_pkg::*;

    queue_entry_t entry_mem [2];
    queue_entry_t entry_in;
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         push;
    logic         do_pop;

    always_comb
    begin
        entry_in.code = char_code;
        case (char_code)
            CH_NEWLINE:   entry_in.op = OP_NEWLINE;
            CH_RETURN:    entry_in.op = OP_RETURN;
            CH_BACKSPACE: entry_in.op = OP_BACKSPACE;
            default:      entry_in.op = OP_GLYPH;
        endcase
    end

    assign in_ready   = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

`default_nettype wire

// ===== design/tccc_back.sv =====
`default_nettype none

module tccc_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tccc_pkg::cursor_cfg_t  cfg,
    input  wire logic                   head_valid,
    input  wire tccc_pkg::queue_entry_t head,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [8:0]                  cell_column,
    output logic [7:0]                  cell_row,
    output logic [7:0]                  glyph,
    output logic [31:0]                 fore_color,
    output logic [31:0]                 back_fill
);
    import tccc_pkg::*;

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [WRAP_W-1:0]  wrap_reg;
    logic [WRAP_W-1:0]  wrap_next;
    logic [ROW_W-1:0]   residue_reg;
    logic [ROW_W-1:0]   residue_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [CHAR_W-1:0]  out_glyph_reg;
    logic [COLOR_W-1:0] out_fore_reg;
    logic [COLOR_W-1:0] out_back_reg;
    logic               emit;
    logic [COL_W-1:0]   emit_col;
    logic [ROW_W-1:0]   emit_row;
    logic [CHAR_W-1:0]  emit_glyph;
    logic [ROW_W-1:0]   row_inc;
    logic [ROW_W-1:0]   row_dec;
    logic [ROW_W:0]     row_back;
    logic               slot_free;

    assign row_inc = (row_reg == cfg.row_last) ? '0 : row_reg + 1'b1;
    assign row_dec = (row_reg == '0) ? cfg.row_last : row_reg - 1'b1;
    assign row_back = {1'b0, row_reg} + {1'b0, cfg.row_last} + 1'b1 - {1'b0, residue_reg};

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        wrap_next    = wrap_reg;
        residue_next = residue_reg;
        emit         = 1'b0;
        emit_col     = col_reg;
        emit_row     = row_reg;
        emit_glyph   = head.code;
        case (head.op)
            OP_NEWLINE:
            begin
                col_next     = '0;
                row_next     = row_inc;
                wrap_next    = '0;
                residue_next = '0;
            end
            OP_RETURN:
            begin
                col_next = '0;
                if (row_reg >= residue_reg)
                begin
                    row_next = row_reg - residue_reg;
                end
                else
                begin
                    row_next = row_back[ROW_W-1:0];
                end
            end
            OP_BACKSPACE:
            begin
                emit_glyph = CH_SPACE;
                if (col_reg != '0)
                begin
                    col_next = col_reg - 1'b1;
                    emit     = 1'b1;
                    emit_col = col_next;
                end
                else if (wrap_reg != '0)
                begin
                    col_next     = cfg.col_last;
                    row_next     = row_dec;
                    wrap_next    = wrap_reg - 1'b1;
                    residue_next = (residue_reg == '0) ? cfg.row_last : residue_reg - 1'b1;
                    emit         = 1'b1;
                    emit_col     = col_next;
                    emit_row     = row_next;
                end
            end
            default:
            begin
                emit = 1'b1;
                if (col_reg == cfg.col_last)
                begin
                    col_next     = '0;
                    row_next     = row_inc;
                    wrap_next    = (wrap_reg != WRAP_MAX) ? wrap_reg + 1'b1 : wrap_reg;
                    residue_next = (residue_reg == cfg.row_last) ? '0 : residue_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign pop = head_valid && (slot_free || !emit);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            wrap_reg      <= '0;
            residue_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg.home)
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                wrap_reg    <= '0;
                residue_reg <= '0;
            end
            else if (pop)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                wrap_reg    <= wrap_next;
                residue_reg <= residue_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_col_reg   <= emit_col;
            out_row_reg   <= emit_row;
            out_glyph_reg <= emit_glyph;
            out_fore_reg  <= cfg.text_color;
            out_back_reg  <= cfg.back_color;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_column = out_col_reg;
    assign cell_row    = out_row_reg;
    assign glyph       = out_glyph_reg;
    assign fore_color  = out_fore_reg;
    assign back_fill   = out_back_reg;

endmodule

`default_nettype wire

// ===== design/text_console_cursor_controller_unit.sv =====
`default_nettype none

// Text console cursor controller: takes one character byte per beat and emits at most one
// cell write (column, row, glyph, colors) per character. It sustains one character per
// clock cycle while the output is not stalled; the rate is set by the cursor update in
// the back end. A character goes from the queue register to the output register, where
// its cell write is held until taken. A two-entry queue separates character intake from
// the cursor update, and the output register lets the next character be accepted while
// a cell write waits to be taken. The configuration port is always ready; a write to any
// defined register homes the cursor and must only be issued while no character is in flight.

module text_console_cursor_controller_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [8:0]       cell_column,
    output logic [7:0]       cell_row,
    output logic [7:0]       glyph,
    output logic [31:0]      fore_color,
    output logic [31:0]      back_fill
);
    import tccc_pkg::*;

    logic [COL_W-1:0]      col_last_reg;
    logic [ROW_W-1:0]      row_last_reg;
    logic [COLOR_W-1:0]    text_color_reg;
    logic [COLOR_W-1:0]    back_color_reg;
    logic                  cfg_write;
    logic [COLS_CFG_W-1:0] cols_value;
    logic [ROWS_CFG_W-1:0] rows_value;
    logic [COLS_CFG_W-1:0] cols_minus;
    logic [ROWS_CFG_W-1:0] rows_minus;
    logic [COL_W-1:0]      col_last_next;
    logic [ROW_W-1:0]      row_last_next;
    cursor_cfg_t           cfg;
    logic                  head_valid;
    queue_entry_t          head;
    logic                  pop;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign cols_value = cfg_data[COLS_CFG_W-1:0];
    assign rows_value = cfg_data[ROWS_CFG_W-1:0];
    assign cols_minus = cols_value - 1'b1;
    assign rows_minus = rows_value - 1'b1;

    always_comb
    begin
        if (cols_value == '0)
        begin
            col_last_next = '0;
        end
        else if (cols_value > MAX_COLUMNS)
        begin
            col_last_next = '1;
        end
        else
        begin
            col_last_next = cols_minus[COL_W-1:0];
        end
        if (rows_value == '0)
        begin
            row_last_next = '0;
        end
        else if (rows_value > MAX_ROWS)
        begin
            row_last_next = '1;
        end
        else
        begin
            row_last_next = rows_minus[ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg   <= RESET_COL_LAST;
            row_last_reg   <= RESET_ROW_LAST;
            text_color_reg <= RESET_TEXT_COLOR;
            back_color_reg <= RESET_BACK_COLOR;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COLUMNS:    col_last_reg   <= col_last_next;
                REG_ROWS:       row_last_reg   <= row_last_next;
                REG_TEXT_COLOR: text_color_reg <= cfg_data;
                REG_BACK_COLOR: back_color_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg.col_last   = col_last_reg;
    assign cfg.row_last   = row_last_reg;
    assign cfg.text_color = text_color_reg;
    assign cfg.back_color = back_color_reg;
    assign cfg.home       = cfg_write && (cfg_index inside {REG_COLUMNS, REG_ROWS,
                            REG_TEXT_COLOR, REG_BACK_COLOR});

    tccc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    tccc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .glyph       (glyph),
        .fore_color  (fore_color),
        .back_fill   (back_fill)
    );

endmodule

`default_nettype wire

// ===== dv/text_console_cursor_controller_unit_tb.sv =====
`default_nettype none

module text_console_cursor_controller_unit_tb;

    import tccc_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [CHAR_W-1:0]  code;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
    } cell_write_t;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 70;
    localparam int SINGLE_COLUMN_ITEMS = 60;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_ready;
    logic [8:0]  cell_column;
    logic [7:0]  cell_row;
    logic [7:0]  glyph;
    logic [31:0] fore_color;
    logic [31:0] back_fill;

    logic [COLS_CFG_W-1:0] screen_columns;
    logic [ROWS_CFG_W-1:0] screen_rows;
    logic [COLOR_W-1:0]    ink_color;
    logic [COLOR_W-1:0]    paper_color;
    logic [COL_W-1:0]      line_pos;
    logic [ROW_W-1:0]      line_no;
    logic [WRAP_W-1:0]     soft_wraps;
    logic [ROW_W-1:0]      wrap_mod;

    cell_write_t expected_writes[$];
    int          error_count;
    int          cycle_count;
    bit          hold_request;
    bit          tx_steady;
    bit          rx_steady;

    text_console_cursor_controller_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_column(cell_column),
        .cell_row   (cell_row),
        .glyph      (glyph),
        .fore_color (fore_color),
        .back_fill  (back_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic op_t classify(input logic [CHAR_W-1:0] c);
        if (c == CH_NEWLINE)
            return OP_NEWLINE;
        else if (c == CH_RETURN)
            return OP_RETURN;
        else if (c == CH_BACKSPACE)
            return OP_BACKSPACE;
        else
            return OP_GLYPH;
    endfunction

    function automatic logic [COLS_CFG_W-1:0] line_width();
        if (screen_columns == '0)
            return 10'd1;
        else if (screen_columns > MAX_COLUMNS)
            return MAX_COLUMNS;
        else
            return screen_columns;
    endfunction

    function automatic logic [ROWS_CFG_W-1:0] screen_height();
        if (screen_rows == '0)
            return 9'd1;
        else if (screen_rows > MAX_ROWS)
            return MAX_ROWS;
        else
            return screen_rows;
    endfunction

    function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROWS_CFG_W-1:0] n);
        logic [ROWS_CFG_W-1:0] s;
        s = {1'b0, r} + 1'b1;
        return (s >= n) ? '0 : s[ROW_W-1:0];
    endfunction

    function automatic void home_cursor();
        line_pos = '0;
        line_no = '0;
        soft_wraps = '0;
        wrap_mod = '0;
    endfunction

    function automatic void push_cell(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                                      input logic [CHAR_W-1:0] code);
        cell_write_t w;
        w.column = col;
        w.row = row;
        w.code = code;
        w.fore = ink_color;
        w.back = paper_color;
        expected_writes.push_back(w);
    endfunction

    function automatic void advance_cursor(input logic [CHAR_W-1:0] c);
        logic [COLS_CFG_W-1:0] ncol;
        logic [ROWS_CFG_W-1:0] nrow;
        logic [COLS_CFG_W-1:0] col_next;
        logic [ROWS_CFG_W-1:0] row_wide;
        ncol = line_width();
        nrow = screen_height();
        case (classify(c))
            OP_NEWLINE:
            begin
                line_pos = '0;
                soft_wraps = '0;
                wrap_mod = '0;
                line_no = next_row(line_no, nrow);
            end
            OP_RETURN:
            begin
                line_pos = '0;
                if (line_no >= wrap_mod)
                    line_no = line_no - wrap_mod;
                else
                begin
                    row_wide = {1'b0, line_no} + nrow - {1'b0, wrap_mod};
                    line_no = row_wide[ROW_W-1:0];
                end
            end
            OP_BACKSPACE:
            begin
                if (line_pos != '0)
                begin
                    line_pos = line_pos - 1'b1;
                    push_cell(line_pos, line_no, CH_SPACE);
                end
                else if (soft_wraps != '0)
                begin
                    col_next = ncol - 1'b1;
                    line_pos = col_next[COL_W-1:0];
                    row_wide = nrow - 1'b1;
                    line_no = (line_no != '0) ? line_no - 1'b1 : row_wide[ROW_W-1:0];
                    soft_wraps = soft_wraps - 1'b1;
                    wrap_mod = (wrap_mod != '0) ? wrap_mod - 1'b1 : row_wide[ROW_W-1:0];
                    push_cell(line_pos, line_no, CH_SPACE);
                end
            end
            default:
            begin
                push_cell(line_pos, line_no, c);
                col_next = {1'b0, line_pos} + 1'b1;
                if (col_next >= ncol)
                begin
                    line_pos = '0;
                    line_no = next_row(line_no, nrow);
                    if (soft_wraps != WRAP_MAX)
                        soft_wraps = soft_wraps + 1'b1;
                    wrap_mod = next_row(wrap_mod, nrow);
                end
                else
                    line_pos = col_next[COL_W-1:0];
            end
        endcase
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        bit hit;
        hit = 1'b1;
        case (idx)
            REG_COLUMNS:    screen_columns = data[COLS_CFG_W-1:0];
            REG_ROWS:       screen_rows = data[ROWS_CFG_W-1:0];
            REG_TEXT_COLOR: ink_color = data;
            REG_BACK_COLOR: paper_color = data;
            default:        hit = 1'b0;
        endcase
        if (hit)
            home_cursor();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] random_glyph();
        logic [CHAR_W-1:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (classify(c) != OP_GLYPH);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return CH_NEWLINE;
        else if (r < 18)
            return CH_RETURN;
        else if (r < 42)
            return CH_BACKSPACE;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] pick_columns();
        logic [COLS_CFG_W-1:0] v;
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 5))
                0:       v = 10'd0;
                1:       v = 10'd1;
                2:       v = 10'd511;
                3:       v = 10'd512;
                4:       v = 10'd513;
                default: v = 10'd1023;
            endcase
        end
        else
            v = 10'($urandom_range(1, 8));
        return ($urandom() & 32'hFFFF_FC00) | 32'(v);
    endfunction

    function automatic logic [31:0] pick_rows();
        logic [ROWS_CFG_W-1:0] v;
        if ($urandom_range(0, 5) == 0)
        begin
            case ($urandom_range(0, 5))
                0:       v = 9'd0;
                1:       v = 9'd1;
                2:       v = 9'd255;
                3:       v = 9'd256;
                4:       v = 9'd257;
                default: v = 9'd511;
            endcase
        end
        else
            v = 9'($urandom_range(1, 4));
        return ($urandom() & 32'hFFFF_FE00) | 32'(v);
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        do
            @(posedge clk);
        while (!in_ready);
        advance_cursor(c);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic set_screen(input logic [31:0] cols, input logic [31:0] rows,
                              input logic [31:0] fore, input logic [31:0] back);
        wait_idle();
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, rows);
        write_reg(REG_TEXT_COLOR, fore);
        write_reg(REG_BACK_COLOR, back);
    endtask

    task automatic test_reset_state();
        send_char(8'h48);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_BACKSPACE);
        send_char(CH_BACKSPACE);
        send_char(CH_BACKSPACE);
        send_char(CH_BACKSPACE);
        send_char(CH_NEWLINE);
        send_char(8'h41);
        send_char(CH_RETURN);
    endtask

    task automatic test_soft_wrap();
        set_screen(32'd2, 32'd3, $urandom(), $urandom());
        send_char(CH_NEWLINE);
        repeat (5) send_char(random_glyph());
        send_char(CH_RETURN);
        send_char(CH_BACKSPACE);
        send_char(CH_BACKSPACE);
        send_char(CH_BACKSPACE);
        repeat (6) send_char(random_glyph());
        send_char(CH_BACKSPACE);
    endtask

    task automatic test_wide_screen();
        set_screen(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        repeat (260) send_char(CH_NEWLINE);
        repeat (520) send_char(random_glyph());
        repeat (12) send_char(CH_BACKSPACE);
        send_char(CH_RETURN);
        wait_idle();
        write_reg(8'hFF, $urandom());
        write_reg(8'($urandom_range(4, 254)), $urandom());
        repeat (3) send_char(random_glyph());
        set_screen(32'd512, 32'd256, 32'h0000_0000, 32'hFFFF_FFFF);
        repeat (20) send_char(random_glyph());
        repeat (5) send_char(CH_BACKSPACE);
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_screen(pick_columns(), pick_rows(), $urandom(), $urandom());
            if ($urandom_range(0, 3) == 0)
                write_reg(8'($urandom_range(4, 255)), $urandom());
            tx_steady = (p % 3 == 2);
            rx_steady = (p % 3 == 2);
            repeat (PHASE_ITEMS) send_char(random_char());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        set_screen(32'd5, 32'd3, $urandom(), $urandom());
        tx_steady = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_char(random_char());
        tx_steady = 1'b0;
    endtask

    task automatic test_single_column();
        set_screen(32'd1, 32'd5, $urandom(), $urandom());
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (SINGLE_COLUMN_ITEMS) send_char(random_glyph());
        send_char(CH_RETURN);
        repeat (3) send_char(CH_BACKSPACE);
        send_char(CH_RETURN);
        send_char(random_glyph());
        send_char(CH_NEWLINE);
        send_char(CH_BACKSPACE);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        int idle_left;
        int hold_left;
        cell_write_t want;
        idle_left = 0;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    $display("%0t: unexpected cell write: expected none, actual col %0d row %0d",
                             $time, cell_column, cell_row);
                    error_count++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    check_field("cell_column", 32'(want.column), 32'(cell_column));
                    check_field("cell_row", 32'(want.row), 32'(cell_row));
                    check_field("glyph", 32'(want.code), 32'(glyph));
                    check_field("fore_color", want.fore, fore_color);
                    check_field("back_fill", want.back, back_fill);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (rx_steady)
                out_ready <= 1'b1;
            else if (idle_left > 0)
            begin
                idle_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                idle_left = pick_gap();
                out_ready <= (idle_left == 0);
                if (idle_left > 0)
                    idle_left--;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        error_count = 0;
        hold_request = 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        char_code <= '0;
        screen_columns = 10'd80;
        screen_rows = 9'd25;
        ink_color = RESET_TEXT_COLOR;
        paper_color = RESET_BACK_COLOR;
        home_cursor();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_soft_wrap();
        test_random_traffic();
        test_wide_screen();
        test_backpressure();
        test_single_column();
        wait_idle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
